[hw/rtl/tre_pkg.sv]
`default_nettype none
package tre_pkg;

  // Channel widths.
  localparam int IN_W    = 32;
  localparam int BASE_W  = 62;
  localparam int EPOCH_W = 63;
  localparam int POS_W   = 34;

  localparam logic [BASE_W-1:0] EPOCH_RESET = 62'd1790985600000;

  // Waypoint table geometry.
  localparam int WAYPOINT_COUNT = 11;
  localparam int ROM_ROWS       = 11;
  localparam int ROW_W          = $clog2(ROM_ROWS);
  localparam int SEG_W          = $clog2(WAYPOINT_COUNT);
  localparam int TIME_W         = 14;
  localparam int SEC_W          = 23;

  // Waypoint times in seconds.
  localparam logic [TIME_W-1:0] WP_TIME [ROM_ROWS] = '{
    14'd0, 14'd600, 14'd1200, 14'd2400, 14'd3600, 14'd4800,
    14'd6000, 14'd6600, 14'd7200, 14'd8400, 14'd9600
  };

  // Latitude in Q8.24 degrees.
  localparam logic signed [31:0] WP_LAT_Q24 [ROM_ROWS] = '{
    32'sd876441764, 32'sd876475318, 32'sd876609536, 32'sd876945080,
    32'sd877448397, 32'sd877951713, 32'sd878455030, 32'sd878790574,
    32'sd878958346, 32'sd879126118, 32'sd879293891
  };

  // Longitude in Q8.24 degrees.
  localparam logic signed [31:0] WP_LON_Q24 [ROM_ROWS] = '{
    -32'sd335544, -32'sd167772, 32'sd167772, 32'sd838861,
    32'sd1677722, 32'sd2684355, 32'sd3690988, 32'sd4362076,
    32'sd4697620, 32'sd5033165, 32'sd5368709
  };

  // Altitude in millimetres.
  localparam logic signed [31:0] WP_ALT_MM [ROM_ROWS] = '{
    32'sd50000, 32'sd3050000, 32'sd6050000, 32'sd12050000,
    32'sd18050000, 32'sd24050000, 32'sd30050000, 32'sd24050000,
    32'sd18050000, 32'sd6050000, 32'sd50000
  };

  // Row lookup; indexes past the table read the final row.
  function automatic logic [ROW_W-1:0] wp_row(input int unsigned i);
    return (i < ROM_ROWS) ? ROW_W'(i) : ROW_W'(ROM_ROWS - 1);
  endfunction

  localparam logic [ROW_W-1:0] LAST_ROW = wp_row(WAYPOINT_COUNT - 1);

  // CORDIC constants, Q2.30.
  localparam int CORDIC_STEPS = 31;
  localparam int CI_W         = 5;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  // Multiplier constants.
  localparam logic [33:0] RECIP_1000 = 34'd274877907;
  localparam logic [33:0] DEG_TO_RAD = 34'd4797524517;
  localparam logic [33:0] E2_Q40     = 34'd7360548640;

  // Radius dividends, millimetres scaled by 2^31.
  localparam logic [63:0] SEMI_DIVIDEND  = 64'd6378137000 << 31;
  localparam logic [63:0] POLAR_DIVIDEND = 64'd6335439327 << 31;

endpackage
`default_nettype wire

[hw/rtl/tre_if.sv]
`default_nettype none
interface tre_in_if import tre_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] run_ms;

  modport source (output valid, output run_ms, input ready);
  modport sink (input valid, input run_ms, output ready);
endinterface

interface tre_out_if import tre_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [EPOCH_W-1:0]      epoch_ms;
  logic signed [POS_W-1:0] x_mm;
  logic signed [POS_W-1:0] y_mm;
  logic signed [POS_W-1:0] z_mm;
  logic                    holding_end;

  modport source (output valid, output epoch_ms, output x_mm, output y_mm, output z_mm,
                  output holding_end, input ready);
  modport sink (input valid, input epoch_ms, input x_mm, input y_mm, input z_mm,
                input holding_end, output ready);
endinterface

interface tre_cfg_if import tre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] epoch_base_ms;

  modport source (output valid, output epoch_base_ms, input ready);
  modport sink (input valid, input epoch_base_ms, output ready);
endinterface
`default_nettype wire

[hw/rtl/trajectory_replay_to_ecef_core.sv]
`default_nettype none
// The shared 64-step restoring divider serves up to three interpolations and two radius
// divisions; CORDIC and the square root run 62 and 32 steps.
// One request is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset returns the sequencer to idle, drops the output and
// loads the epoch base with its default.
module trajectory_replay_to_ecef_core import tre_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tre_in_if.sink     in_ch,
  tre_out_if.source  out_ch,
  tre_cfg_if.sink    cfg_ch
);

  localparam int VAL_W  = 41;
  localparam int MAG_W  = 34;
  localparam int PROD_W = 68;
  localparam int SQ_W   = 63;

  localparam logic [1:0] FLD_LAT = 2'd0;
  localparam logic [1:0] FLD_LON = 2'd1;
  localparam logic [1:0] FLD_ALT = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEC, ST_SEG, ST_IMUL, ST_IDIV, ST_IWAIT, ST_RADM, ST_RADR, ST_CORD,
    ST_S2M, ST_S2R, ST_E2M, ST_E2R, ST_SQRT, ST_NWAIT, ST_ZWAIT, ST_HCM, ST_HCR,
    ST_XM, ST_XR, ST_YM, ST_YR, ST_ZM, ST_ZR, ST_DONE
  } state_t;

  state_t                  state_r;
  logic [IN_W-1:0]         ms_r;
  logic                    hold_r;
  logic [ROW_W-1:0]        a_row_r, b_row_r;
  logic [TIME_W-1:0]       span_r, num_r;
  logic [1:0]              fld_r;
  logic signed [VAL_W-1:0] lat_r, lon_r, h_r, t_r, n_r, nz_r, x_r, y_r, z_r;
  logic                    cpass_r;
  logic signed [MAG_W-1:0] cx_r, cy_r, cz_r;
  logic [CI_W-1:0]         ci_r;
  logic signed [MAG_W-1:0] slat_r, clat_r, slon_r, clon_r;
  logic [PROD_W-1:0]       p_r;
  logic                    mneg_r, dneg_r;
  logic [63:0]             div_quo_r;
  logic [31:0]             div_rem_r, div_den_r;
  logic [5:0]              div_cnt_r;
  logic [SQ_W-1:0]         sq_v_r, sq_res_r, sq_bit_r;
  logic [BASE_W-1:0]       base_r;
  logic                    ov_r;
  logic [EPOCH_W-1:0]      o_epoch_r;
  logic [POS_W-1:0]        o_x_r, o_y_r, o_z_r;
  logic                    o_hold_r;

  // Magnitude of a signed value, cut to the multiplier width.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    m = (v < 0) ? VAL_W'(-v) : VAL_W'(v);
    return m[MAG_W-1:0];
  endfunction

  // Waypoint field read.
  function automatic logic signed [VAL_W-1:0] wp_val(input logic [1:0] fld,
                                                     input logic [ROW_W-1:0] rw);
    logic signed [VAL_W-1:0] v;
    case (fld)
      FLD_LAT: v = VAL_W'(WP_LAT_Q24[rw]);
      FLD_LON: v = VAL_W'(WP_LON_Q24[rw]);
      default: v = VAL_W'(WP_ALT_MM[rw]);
    endcase
    return v;
  endfunction

  // Segment selection from the whole seconds held in the product register.
  logic [SEC_W-1:0]  sec_c;
  logic              hold_c;
  logic [SEG_W-1:0]  seg_c;
  logic [ROW_W-1:0]  a_row_c, b_row_c;
  logic [TIME_W-1:0] span_c, num_c;

  always_comb begin
    sec_c  = p_r[38 +: SEC_W];
    hold_c = sec_c >= SEC_W'(WP_TIME[LAST_ROW]);
    seg_c  = '0;
    for (int i = 0; i < WAYPOINT_COUNT - 1; i++) begin
      if (sec_c >= SEC_W'(WP_TIME[wp_row(i)])) seg_c = SEG_W'(i);
    end
    a_row_c = wp_row(32'(seg_c));
    b_row_c = wp_row(32'(seg_c) + 1);
    span_c  = (WP_TIME[b_row_c] > WP_TIME[a_row_c]) ?
              WP_TIME[b_row_c] - WP_TIME[a_row_c] : '0;
    num_c   = TIME_W'(sec_c - SEC_W'(WP_TIME[a_row_c]));
  end

  // Shared multiplier operand selection.
  logic signed [VAL_W-1:0] diff_c, lat_lon_c, nh_c, nzh_c;
  logic [MAG_W-1:0]        mul_a, mul_b;
  logic                    mul_neg;

  always_comb begin
    diff_c    = wp_val(fld_r, b_row_r) - wp_val(fld_r, a_row_r);
    lat_lon_c = cpass_r ? lon_r : lat_r;
    nh_c      = n_r + h_r;
    nzh_c     = nz_r + h_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    case (state_r)
      ST_SEC: begin
        mul_a = MAG_W'(ms_r);
        mul_b = RECIP_1000;
      end
      ST_IMUL: begin
        mul_a   = mag_of(diff_c);
        mul_b   = MAG_W'(num_r);
        mul_neg = diff_c < 0;
      end
      ST_RADM: begin
        mul_a   = mag_of(lat_lon_c);
        mul_b   = DEG_TO_RAD;
        mul_neg = lat_lon_c < 0;
      end
      ST_S2M: begin
        mul_a = mag_of(VAL_W'(slat_r));
        mul_b = mag_of(VAL_W'(slat_r));
      end
      ST_E2M: begin
        mul_a = E2_Q40;
        mul_b = mag_of(t_r);
      end
      ST_HCM: begin
        mul_a   = mag_of(nh_c);
        mul_b   = mag_of(VAL_W'(clat_r));
        mul_neg = (nh_c < 0) != (clat_r < 0);
      end
      ST_XM: begin
        mul_a   = mag_of(t_r);
        mul_b   = mag_of(VAL_W'(clon_r));
        mul_neg = (t_r < 0) != (clon_r < 0);
      end
      ST_YM: begin
        mul_a   = mag_of(t_r);
        mul_b   = mag_of(VAL_W'(slon_r));
        mul_neg = (t_r < 0) != (slon_r < 0);
      end
      ST_ZM: begin
        mul_a   = mag_of(nzh_c);
        mul_b   = mag_of(VAL_W'(slat_r));
        mul_neg = (nzh_c < 0) != (slat_r < 0);
      end
      default: ;
    endcase
  end

  // Rounding of the registered product, ties away from zero.
  logic [PROD_W-1:0]       r30_sum, r32_sum;
  logic [VAL_W-2:0]        r30_mag, r32_mag;
  logic signed [VAL_W-1:0] r30_v, r32_v, w_c;

  always_comb begin
    r30_sum = (p_r + (PROD_W'(1) << 29)) >> 30;
    r32_sum = (p_r + (PROD_W'(1) << 31)) >> 32;
    r30_mag = r30_sum[VAL_W-2:0];
    r32_mag = r32_sum[VAL_W-2:0];
    r30_v   = mneg_r ? -$signed({1'b0, r30_mag}) : $signed({1'b0, r30_mag});
    r32_v   = mneg_r ? -$signed({1'b0, r32_mag}) : $signed({1'b0, r32_mag});
    w_c     = (VAL_W'(1) <<< 40) - r30_v;
    if (w_c < 1) w_c = VAL_W'(1);
  end

  // One restoring divider step.
  logic [32:0]             div_sh;
  logic                    div_ge;
  logic [31:0]             div_rem_nxt;
  logic [63:0]             div_quo_nxt;
  logic signed [VAL_W-1:0] div_q_c;

  always_comb begin
    div_sh      = {div_rem_r, div_quo_r[63]};
    div_ge      = div_sh >= {1'b0, div_den_r};
    div_rem_nxt = div_ge ? 32'(div_sh - {1'b0, div_den_r}) : div_sh[31:0];
    div_quo_nxt = {div_quo_r[62:0], div_ge};
    div_q_c     = dneg_r ? -$signed({1'b0, div_quo_nxt[VAL_W-2:0]}) :
                  $signed({1'b0, div_quo_nxt[VAL_W-2:0]});
  end

  // One CORDIC rotation step.
  logic signed [MAG_W-1:0] cdx, cdy, catan, cx_nxt, cy_nxt, cz_nxt;

  always_comb begin
    cdx   = cy_r >>> ci_r;
    cdy   = cx_r >>> ci_r;
    catan = $signed(MAG_W'(ATAN_Q30[ci_r]));
    if (cz_r >= 0) begin
      cx_nxt = cx_r - cdx;
      cy_nxt = cy_r + cdy;
      cz_nxt = cz_r - catan;
    end else begin
      cx_nxt = cx_r + cdx;
      cy_nxt = cy_r - cdy;
      cz_nxt = cz_r + catan;
    end
  end

  // One bitwise square root step.
  logic [SQ_W-1:0] sq_trial, sq_v_nxt, sq_res_nxt;
  logic            sq_ge;
  logic [31:0]     r_c;

  always_comb begin
    sq_trial   = sq_res_r + sq_bit_r;
    sq_ge      = sq_v_r >= sq_trial;
    sq_v_nxt   = sq_ge ? sq_v_r - sq_trial : sq_v_r;
    sq_res_nxt = sq_ge ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;
    r_c        = (sq_res_nxt == '0) ? 32'd1 : sq_res_nxt[31:0];
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = ov_r;
  assign out_ch.epoch_ms    = o_epoch_r;
  assign out_ch.x_mm        = o_x_r;
  assign out_ch.y_mm        = o_y_r;
  assign out_ch.z_mm        = o_z_r;
  assign out_ch.holding_end = o_hold_r;

  // Sequencer, shared units and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      base_r  <= EPOCH_RESET;
    end else begin
      p_r    <= PROD_W'(mul_a) * PROD_W'(mul_b);
      mneg_r <= mul_neg;

      if (cfg_ch.valid) base_r <= cfg_ch.epoch_base_ms;

      // The output register fills when a result is loaded and empties when taken.
      if (state_r == ST_DONE && (!ov_r || out_ch.ready)) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ms_r    <= in_ch.run_ms;
            state_r <= ST_SEC;
          end
        end
        ST_SEC: state_r <= ST_SEG;
        ST_SEG: begin
          hold_r  <= hold_c;
          a_row_r <= a_row_c;
          b_row_r <= b_row_c;
          span_r  <= span_c;
          num_r   <= num_c;
          fld_r   <= FLD_LAT;
          cpass_r <= 1'b0;
          if (hold_c) begin
            lat_r   <= wp_val(FLD_LAT, LAST_ROW);
            lon_r   <= wp_val(FLD_LON, LAST_ROW);
            h_r     <= wp_val(FLD_ALT, LAST_ROW);
            state_r <= ST_RADM;
          end else begin
            lat_r   <= wp_val(FLD_LAT, a_row_c);
            lon_r   <= wp_val(FLD_LON, a_row_c);
            h_r     <= wp_val(FLD_ALT, a_row_c);
            state_r <= ST_IMUL;
          end
        end
        ST_IMUL: begin
          if (span_r == '0) begin
            if (fld_r == FLD_ALT) state_r <= ST_RADM;
            else fld_r <= fld_r + 2'd1;
          end else begin
            state_r <= ST_IDIV;
          end
        end
        ST_IDIV: begin
          div_quo_r <= p_r[63:0] + 64'(span_r >> 1);
          div_den_r <= 32'(span_r);
          div_rem_r <= '0;
          div_cnt_r <= '1;
          dneg_r    <= mneg_r;
          state_r   <= ST_IWAIT;
        end
        ST_IWAIT: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == '0) begin
            case (fld_r)
              FLD_LAT: lat_r <= lat_r + div_q_c;
              FLD_LON: lon_r <= lon_r + div_q_c;
              default: h_r <= h_r + div_q_c;
            endcase
            if (fld_r == FLD_ALT) begin
              state_r <= ST_RADM;
            end else begin
              fld_r   <= fld_r + 2'd1;
              state_r <= ST_IMUL;
            end
          end
        end
        ST_RADM: state_r <= ST_RADR;
        ST_RADR: begin
          cz_r    <= MAG_W'(r32_v);
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          ci_r    <= '0;
          state_r <= ST_CORD;
        end
        ST_CORD: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          ci_r <= ci_r + CI_W'(1);
          if (ci_r == CI_W'(CORDIC_STEPS - 1)) begin
            if (!cpass_r) begin
              slat_r  <= cy_nxt;
              clat_r  <= cx_nxt;
              cpass_r <= 1'b1;
              state_r <= ST_RADM;
            end else begin
              slon_r  <= cy_nxt;
              clon_r  <= cx_nxt;
              state_r <= ST_S2M;
            end
          end
        end
        ST_S2M: state_r <= ST_S2R;
        ST_S2R: begin
          t_r     <= r30_v;
          state_r <= ST_E2M;
        end
        ST_E2M: state_r <= ST_E2R;
        ST_E2R: begin
          sq_v_r   <= {w_c[VAL_W-1:0], 22'd0};
          sq_res_r <= '0;
          sq_bit_r <= SQ_W'(1) << (SQ_W - 1);
          state_r  <= ST_SQRT;
        end
        ST_SQRT: begin
          sq_v_r   <= sq_v_nxt;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r[0]) begin
            div_quo_r <= SEMI_DIVIDEND + 64'(r_c >> 1);
            div_den_r <= r_c;
            div_rem_r <= '0;
            div_cnt_r <= '1;
            dneg_r    <= 1'b0;
            state_r   <= ST_NWAIT;
          end
        end
        ST_NWAIT: begin
          if (div_cnt_r == '0) begin
            n_r       <= div_q_c;
            div_quo_r <= POLAR_DIVIDEND + 64'(div_den_r >> 1);
            div_rem_r <= '0;
            div_cnt_r <= '1;
            state_r   <= ST_ZWAIT;
          end else begin
            div_quo_r <= div_quo_nxt;
            div_rem_r <= div_rem_nxt;
            div_cnt_r <= div_cnt_r - 6'd1;
          end
        end
        ST_ZWAIT: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == '0) begin
            nz_r    <= div_q_c;
            state_r <= ST_HCM;
          end
        end
        ST_HCM: state_r <= ST_HCR;
        ST_HCR: begin
          t_r     <= r30_v;
          state_r <= ST_XM;
        end
        ST_XM: state_r <= ST_XR;
        ST_XR: begin
          x_r     <= r30_v;
          state_r <= ST_YM;
        end
        ST_YM: state_r <= ST_YR;
        ST_YR: begin
          y_r     <= r30_v;
          state_r <= ST_ZM;
        end
        ST_ZM: state_r <= ST_ZR;
        ST_ZR: begin
          z_r     <= r30_v;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // Wait until the previous result has left the output register.
          if (!ov_r || out_ch.ready) begin
            o_epoch_r <= EPOCH_W'(base_r) + EPOCH_W'(ms_r);
            o_x_r     <= x_r[POS_W-1:0];
            o_y_r     <= y_r[POS_W-1:0];
            o_z_r     <= z_r[POS_W-1:0];
            o_hold_r  <= hold_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/tre_checker.sv]
`default_nettype none
module tre_checker import tre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tre_in_if         in_ch,
  tre_out_if        out_ch,
  tre_cfg_if        cfg_ch,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    logic [EPOCH_W-1:0]      epoch_ms;
    logic signed [POS_W-1:0] x_mm;
    logic signed [POS_W-1:0] y_mm;
    logic signed [POS_W-1:0] z_mm;
    logic                    holding_end;
  } fix_t;

  // Waypoints: seconds, 1e-4 degrees, whole metres.
  localparam int unsigned ROUTE_T   [11] = '{0, 600, 1200, 2400, 3600, 4800, 6000, 6600,
                                             7200, 8400, 9600};
  localparam int          ROUTE_LAT [11] = '{522400, 522420, 522500, 522700, 523000, 523300,
                                             523600, 523800, 523900, 524000, 524100};
  localparam int          ROUTE_LON [11] = '{-200, -100, 100, 500, 1000, 1600, 2200, 2600,
                                             2800, 3000, 3200};
  localparam int          ROUTE_ALT [11] = '{50, 3050, 6050, 12050, 18050, 24050, 30050,
                                             24050, 18050, 6050, 50};

  logic [BASE_W-1:0] epoch_base;
  fix_t              fix_q[$];

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Division rounded to nearest, ties away from zero.
  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return 0;
    q = (abs64(num) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint unsigned p;
    p = abs64(a) * abs64(b);
    p = (p + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  // Rotation-mode CORDIC on a Q8.24 degree angle; sine and cosine in Q2.30.
  function automatic void sin_cos(longint deg, output longint s, output longint c);
    longint unsigned zm;
    longint z, x, y, dx, dy;
    zm = (abs64(deg) * longint'(DEG_TO_RAD) + (64'd1 << 31)) >> 32;
    z = (deg < 0) ? -longint'(zm) : longint'(zm);
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint to_q24(int v);
    return div_round(longint'(v) * 16777216, 10000);
  endfunction

  function automatic longint lerp(longint a, longint b, int unsigned num, int unsigned span);
    if (span == 0) return a;
    return a + div_round((b - a) * longint'(num), span);
  endfunction

  function automatic int clamp_row(int i);
    return (i < 11) ? i : 10;
  endfunction

  // Position and timestamp for one elapsed-time request.
  function automatic fix_t predict_fix(logic [IN_W-1:0] ms, logic [BASE_W-1:0] base);
    fix_t f;
    int unsigned sec, span, num;
    int seg, a, b, last;
    longint lat, lon, h, slat, clat, slon, clon, s2, e2t, w, hc;
    longint unsigned r, n, nz;
    sec = ms / 1000;
    last = clamp_row(WAYPOINT_COUNT - 1);
    f.holding_end = (sec >= ROUTE_T[last]);
    if (f.holding_end) begin
      lat = to_q24(ROUTE_LAT[last]);
      lon = to_q24(ROUTE_LON[last]);
      h = longint'(ROUTE_ALT[last]) * 1000;
    end else begin
      seg = 0;
      for (int i = 0; i + 1 < WAYPOINT_COUNT; i++)
        if (sec >= ROUTE_T[clamp_row(i)]) seg = i;
      a = clamp_row(seg);
      b = clamp_row(seg + 1);
      span = (ROUTE_T[b] > ROUTE_T[a]) ? ROUTE_T[b] - ROUTE_T[a] : 0;
      num = sec - ROUTE_T[a];
      lat = lerp(to_q24(ROUTE_LAT[a]), to_q24(ROUTE_LAT[b]), num, span);
      lon = lerp(to_q24(ROUTE_LON[a]), to_q24(ROUTE_LON[b]), num, span);
      h = lerp(longint'(ROUTE_ALT[a]) * 1000, longint'(ROUTE_ALT[b]) * 1000, num, span);
    end
    sin_cos(lat, slat, clat);
    sin_cos(lon, slon, clon);
    // Prime vertical radius from the squared latitude sine.
    s2 = (abs64(slat) * abs64(slat) + (64'd1 << 29)) >> 30;
    e2t = (longint'(E2_Q40) * s2 + (64'd1 << 29)) >> 30;
    w = (64'sd1 << 40) - e2t;
    if (w < 1) w = 1;
    r = sqrt_floor(longint'(w) << 22);
    if (r < 1) r = 1;
    n = (SEMI_DIVIDEND + r / 2) / r;
    nz = (POLAR_DIVIDEND + r / 2) / r;
    hc = mul_q30(longint'(n) + h, clat);
    f.epoch_ms = EPOCH_W'(64'(base) + 64'(ms));
    f.x_mm = POS_W'(mul_q30(hc, clon));
    f.y_mm = POS_W'(mul_q30(hc, slon));
    f.z_mm = POS_W'(mul_q30(longint'(nz) + h, slat));
    return f;
  endfunction

  assign pending = fix_q.size();

  always @(posedge clk) begin
    fix_t want;
    if (!rst_n) begin
      errors = 0;
      epoch_base <= EPOCH_RESET;
    end else begin
      // Compare a delivered fix with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (fix_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result epoch=%0d x=%0d y=%0d z=%0d hold=%0b", $time,
                   out_ch.epoch_ms, out_ch.x_mm, out_ch.y_mm, out_ch.z_mm, out_ch.holding_end);
        end else begin
          want = fix_q.pop_front();
          if (want.epoch_ms !== out_ch.epoch_ms) begin
            errors++;
            $display("%0t: epoch_ms expected %0d actual %0d", $time, want.epoch_ms,
                     out_ch.epoch_ms);
          end
          if (want.x_mm !== out_ch.x_mm) begin
            errors++;
            $display("%0t: x_mm expected %0d actual %0d", $time, want.x_mm, out_ch.x_mm);
          end
          if (want.y_mm !== out_ch.y_mm) begin
            errors++;
            $display("%0t: y_mm expected %0d actual %0d", $time, want.y_mm, out_ch.y_mm);
          end
          if (want.z_mm !== out_ch.z_mm) begin
            errors++;
            $display("%0t: z_mm expected %0d actual %0d", $time, want.z_mm, out_ch.z_mm);
          end
          if (want.holding_end !== out_ch.holding_end) begin
            errors++;
            $display("%0t: holding_end expected %0b actual %0b", $time, want.holding_end,
                     out_ch.holding_end);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        fix_q.push_back(predict_fix(in_ch.run_ms, epoch_base));
      if (cfg_ch.valid && cfg_ch.ready)
        epoch_base <= cfg_ch.epoch_base_ms;
    end
  end

endmodule
`default_nettype wire

[tb/tb_trajectory_replay_to_ecef_core.sv]
`default_nettype none
module tb_trajectory_replay_to_ecef_core import tre_pkg::*; ();

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE       = 600;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AT      = 120;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   cycles;
  int   results;
  bit   calm_in;
  bit   calm_out;

  tre_in_if  in_ch ();
  tre_out_if out_ch ();
  tre_cfg_if cfg_ch ();

  trajectory_replay_to_ecef_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tre_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(logic [IN_W-1:0] ms);
    int gap;
    if ($urandom_range(0, 19) == 0) calm_in = ~calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.run_ms <= ms;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_base(logic [BASE_W-1:0] base);
    @(negedge clk);
    in_ch.valid          <= 1'b0;
    cfg_ch.valid         <= 1'b1;
    cfg_ch.epoch_base_ms <= base;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Withdraw the last request and wait until every result is out.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly trajectory times, some near waypoint seconds, some anywhere.
  function automatic logic [IN_W-1:0] pick_time();
    int unsigned k;
    int unsigned wp_s [11] = '{0, 600, 1200, 2400, 3600, 4800, 6000, 6600, 7200, 8400, 9600};
    int unsigned near_ms [4] = '{0, 1, 999, 1000};
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(0, 9700000);
    if (k < 8) return wp_s[$urandom_range(0, 10)] * 1000 + near_ms[$urandom_range(0, 3)] - 1;
    return $urandom();
  endfunction

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int wait_n;
    results  = 0;
    calm_out = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) calm_out = ~calm_out;
      wait_n = calm_out ? 0 : $urandom_range(0, 5);
      if (results == HOLD_AT) wait_n = HOLD_CYCLES;
      repeat (wait_n) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results++;
    end
  end

  initial begin
    logic [IN_W-1:0] directed [$] = '{
      32'd0, 32'd999, 32'd1000, 32'd599999, 32'd600000, 32'd600999, 32'd1199999,
      32'd1800000, 32'd3000000, 32'd4200000, 32'd5400000, 32'd6000000, 32'd6300000,
      32'd6900000, 32'd7800000, 32'd9000000, 32'd9599999, 32'd9600000, 32'd9600001,
      32'd10000000, 32'h7FFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF
    };
    logic [BASE_W-1:0] bases [4];
    rst_n                = 1'b0;
    calm_in              = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.run_ms         = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.epoch_base_ms = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset epoch base first, then the extremes, a random base and the reset value again.
    foreach (directed[i]) send_request(directed[i]);
    bases[0] = '0;
    bases[1] = '1;
    bases[2] = BASE_W'({$urandom(), $urandom()});
    bases[3] = EPOCH_RESET;
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        write_base(bases[p-1]);
      end
      for (int j = 0; j < 150; j++) send_request(pick_time());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/tre_pkg.sv
hw/rtl/tre_if.sv
hw/rtl/trajectory_replay_to_ecef_core.sv
tb/tre_checker.sv
tb/tb_trajectory_replay_to_ecef_core.sv
